[hdl/ldr2_pkg.sv]
package ldr2_pkg;

   localparam int NUM_W = 72;
   localparam int DEN_W = 64;
   localparam int STEP_W = $clog2(NUM_W);
   localparam int FRAC_W = 24;
   localparam logic [FRAC_W:0] FONE = 25'h1000000;
   localparam logic [8:0] SMALL_MAX = 9'd511;
   localparam logic [39:0] SUM_MAX = 40'hFF_FFFF_FFFF;
   localparam logic [31:0] WORD_MAX = 32'hFFFF_FFFF;

   localparam logic CSR_SAMPLE_COUNT = 1'b0;
   localparam logic CSR_RARE_THRESHOLD = 1'b1;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 80;

endpackage

[hdl/ldr2_div.sv]
module ldr2_div import ldr2_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [NUM_W-1:0] quot,
   output logic             done
);

   logic              busy_ff;
   logic              done_ff;
   logic [STEP_W-1:0] step_ff;
   logic [DEN_W-1:0]  rem_ff;
   logic [DEN_W-1:0]  den_ff;
   logic [NUM_W-1:0]  quo_ff;
   logic [DEN_W:0]    shifted;
   logic [DEN_W:0]    diff;
   logic              fits;
   logic [DEN_W-1:0]  rem_in;

   always_comb begin
      shifted = {rem_ff, quo_ff[NUM_W-1]};
      diff    = shifted - {1'b0, den_ff};
      fits    = shifted >= {1'b0, den_ff};
      rem_in  = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (busy_ff) begin
            rem_ff <= rem_in;
            quo_ff <= {quo_ff[NUM_W-2:0], fits};
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_W'(NUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end else if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
            rem_ff  <= '0;
            quo_ff  <= num;
            den_ff  <= den;
         end
      end
   end

   assign quot = quo_ff;
   assign done = done_ff;

endmodule

[hdl/composite_ld_r2_engine_core.sv]
// A sample that does not close a table is accepted one per cycle while the input is ready.
// A closing sample has its result beat offered after seven divisions in the shared
// radix-2 divider plus multiply and update steps; the r2 division is skipped when the
// denominator is zero, and up to three more divisions follow when it also closes the locus pair.
// The input is not ready from the closing sample until its result beat is taken.
// Reset: synchronous; clears the count table, the locus accumulators and the sequencer,
// and sets sample_count to 2 and rare_threshold to 0.
module composite_ld_r2_engine_core import ldr2_pkg::*; #(
   parameter int COUNT_WIDTH = 16,
   parameter int MAX_ALLELES = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // dosage_first[1:0], dosage_second[3:2], alleles_first[8:4], alleles_second[13:9]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,
   // last_allele_pair
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // pair_r2[31:0], pair_dropped[32], first_rare[33], second_rare[34],
   // zero_denominator[35], locus_valid[36], locus_mean_r2[68:37],
   // locus_weight[77:69], all_dropped[78]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [15:0]           csr_wdata
);

   localparam int CW = COUNT_WIDTH;
   localparam int FW = CW + 4;
   localparam int SW = CW + 6;
   localparam int KW = $clog2(MAX_ALLELES + 1);

   typedef enum logic [4:0] {
      ST_IDLE, ST_THR, ST_FILT, ST_DP, ST_DQ, ST_DHJ, ST_DHI, ST_DS, ST_MPQ,
      ST_DELTA, ST_MDN, ST_DMAG, ST_V1A, ST_V1B, ST_V1, ST_V2A, ST_V2B, ST_V2,
      ST_MNUM, ST_MDEN, ST_DR2, ST_FIN, ST_DMEAN, ST_DW1, ST_DW2, ST_MW,
      ST_WGT, ST_OUT
   } state_type;

   state_type        state_ff;
   logic [15:0]      sample_count_ff;
   logic [15:0]      rare_thr_ff;
   logic [CW-1:0]    t_ff [9];
   logic [FW-1:0]    ft_ff [9];
   logic             go_ff;
   logic             lastp_ff;
   logic [KW-1:0]    k1_ff, k2_ff;
   logic [FRAC_W:0]  p_ff, q_ff, hj_ff, hi_ff;
   logic [FRAC_W+1:0] s_ff;
   logic [26:0]      dmag_ff;
   logic [27:0]      mag_ff;
   logic [51:0]      va_ff;
   logic [27:0]      v1mag_ff, v2mag_ff;
   logic             v1neg_ff, v2neg_ff;
   logic [55:0]      num_ff;
   logic [63:0]      prod_ff;
   logic [31:0]      r2_ff;
   logic             zden_ff;
   logic             drop_ff, rare1_ff, rare2_ff;
   logic [39:0]      r2sum_ff;
   logic [8:0]       pc_ff, dc_ff, frc_ff, src_ff;
   logic             lvalid_ff;
   logic [31:0]      mean_ff;
   logic [KW-1:0]    part1_ff, part2_ff;
   logic [8:0]       weight_ff;
   logic             alldrop_ff;

   logic [15:0]      n;
   logic [1:0]       d1, d2;
   logic [3:0]       cell_idx;
   logic [7:0]       k1_ext, k2_ext;
   logic [KW-1:0]    k1_in, k2_in;
   logic [FW-1:0]    a [9];
   logic [FW-1:0]    b [9];
   logic [FW-1:0]    f [9];
   logic [FW-1:0]    ur1, ur2, uc1, uc2;
   logic             col_a, col_b;
   logic [SW-1:0]    fr0, fr1, fc0, fc1;
   logic [NUM_W-1:0] pnum, qnum, hjnum, hinum, snum;
   logic [31:0]      mul_a, mul_b;
   logic [63:0]      prod_in;
   logic             div_start;
   logic             div_done;
   logic [NUM_W-1:0] div_num;
   logic [DEN_W-1:0] div_den;
   logic [NUM_W-1:0] quot;
   logic [25:0]      twopq;
   logic [26:0]      delta;
   logic [51:0]      v_in;
   logic [51:0]      vabs;
   logic             zero_den;
   logic [39:0]      r2_final;
   logic [40:0]      sum_in;
   logic [8:0]       kept;
   logic             rare1_in, rare2_in;
   logic             skip;

   assign n = (sample_count_ff < 16'd2) ? 16'd2 : sample_count_ff;

   always_comb begin
      d1 = (req_tdata[1:0] > 2'd2) ? 2'd2 : req_tdata[1:0];
      d2 = (req_tdata[3:2] > 2'd2) ? 2'd2 : req_tdata[3:2];
      cell_idx = ({2'b0, d1} * 4'd3) + {2'b0, d2};
      k1_ext = {3'b0, req_tdata[8:4]};
      k2_ext = {3'b0, req_tdata[13:9]};
      if (k1_ext == 8'd0) k1_ext = 8'd1;
      else if (k1_ext > 8'(MAX_ALLELES)) k1_ext = 8'(MAX_ALLELES);
      if (k2_ext == 8'd0) k2_ext = 8'd1;
      else if (k2_ext > 8'(MAX_ALLELES)) k2_ext = 8'(MAX_ALLELES);
      k1_in = k1_ext[KW-1:0];
      k2_in = k2_ext[KW-1:0];
   end

   // filter on the unfiltered table, rows first then columns
   always_comb begin
      for (int i = 0; i < 9; i++) a[i] = FW'(t_ff[i]);
      ur1 = a[3] + a[4] + a[5];
      ur2 = a[6] + a[7] + a[8];
      uc1 = a[1] + a[4] + a[7];
      uc2 = a[2] + a[5] + a[8];
      col_a = ((64'(ur1) + (64'(ur2) << 1)) << 16) < prod_ff;
      col_b = ((64'(uc1) + (64'(uc2) << 1)) << 16) < prod_ff;
      for (int i = 0; i < 9; i++) b[i] = a[i];
      if (col_a) begin
         for (int j = 0; j < 3; j++) begin
            b[j]     = a[j] + a[3+j] + a[6+j];
            b[3+j]   = '0;
            b[6+j]   = '0;
         end
      end
      for (int i = 0; i < 9; i++) f[i] = b[i];
      if (col_b) begin
         for (int i = 0; i < 3; i++) begin
            f[i*3]   = b[i*3] + b[i*3+1] + b[i*3+2];
            f[i*3+1] = '0;
            f[i*3+2] = '0;
         end
      end
   end

   always_comb begin
      fr0 = SW'(ft_ff[0]) + SW'(ft_ff[1]) + SW'(ft_ff[2]);
      fr1 = SW'(ft_ff[3]) + SW'(ft_ff[4]) + SW'(ft_ff[5]);
      fc0 = SW'(ft_ff[0]) + SW'(ft_ff[3]) + SW'(ft_ff[6]);
      fc1 = SW'(ft_ff[1]) + SW'(ft_ff[4]) + SW'(ft_ff[7]);
      pnum  = ((NUM_W'(fr0) << 1) + NUM_W'(fr1)) << FRAC_W;
      qnum  = ((NUM_W'(fc0) << 1) + NUM_W'(fc1)) << FRAC_W;
      hjnum = NUM_W'(fr0) << FRAC_W;
      hinum = NUM_W'(fc0) << FRAC_W;
      snum  = ((NUM_W'(ft_ff[0]) << 2) + (NUM_W'(ft_ff[3]) << 1) +
               (NUM_W'(ft_ff[1]) << 1) + NUM_W'(ft_ff[4])) << FRAC_W;
   end

   always_comb begin
      twopq = prod_ff[48:23];
      delta = {1'b0, s_ff} - {1'b0, twopq};
      v_in  = va_ff - prod_ff[51:0];
      vabs  = v_in[51] ? (52'd0 - v_in) : v_in;
      zero_den = (v1mag_ff == '0) || (v2mag_ff == '0) || (v1neg_ff != v2neg_ff);
      rare1_in = (FONE - p_ff) < {1'b0, rare_thr_ff, 8'b0};
      rare2_in = (FONE - q_ff) < {1'b0, rare_thr_ff, 8'b0};
      r2_final = (rare1_in || rare2_in) ? 40'd0 : 40'(r2_ff);
      sum_in = {1'b0, r2sum_ff} + {1'b0, r2_final};
      kept = (pc_ff > dc_ff) ? (pc_ff - dc_ff) : 9'd0;
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_THR: begin mul_a = 32'(rare_thr_ff); mul_b = 32'(n); end
         ST_MPQ: begin mul_a = 32'(p_ff); mul_b = 32'(q_ff); end
         ST_MDN: begin mul_a = 32'(dmag_ff); mul_b = 32'(n); end
         ST_V1A: begin mul_a = 32'(p_ff); mul_b = 32'(FONE - p_ff); end
         ST_V1B: begin mul_a = 32'(p_ff); mul_b = 32'(p_ff); end
         ST_V2A: begin mul_a = 32'(q_ff); mul_b = 32'(FONE - q_ff); end
         ST_V2B: begin mul_a = 32'(q_ff); mul_b = 32'(q_ff); end
         ST_MNUM: begin mul_a = 32'(mag_ff); mul_b = 32'(mag_ff); end
         ST_MDEN: begin mul_a = 32'(v1mag_ff); mul_b = 32'(v2mag_ff); end
         ST_MW: begin mul_a = 32'(part1_ff); mul_b = 32'(part2_ff); end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
      prod_in = mul_a * mul_b;
   end

   always_comb begin
      div_num = '0;
      div_den = '0;
      skip = 1'b0;
      unique case (state_ff)
         ST_DP: begin div_num = pnum; div_den = DEN_W'({n, 1'b0}); end
         ST_DQ: begin div_num = qnum; div_den = DEN_W'({n, 1'b0}); end
         ST_DHJ: begin div_num = hjnum; div_den = DEN_W'(n); end
         ST_DHI: begin div_num = hinum; div_den = DEN_W'(n); end
         ST_DS: begin div_num = snum; div_den = DEN_W'({n, 1'b0}); end
         ST_DMAG: begin div_num = NUM_W'(prod_ff); div_den = DEN_W'(n - 16'd1); end
         ST_DR2: begin
            div_num = {num_ff, 16'b0};
            div_den = prod_ff;
            skip = zero_den;
         end
         ST_DMEAN: begin
            div_num = NUM_W'(r2sum_ff);
            div_den = DEN_W'(kept);
            skip = (kept == 9'd0);
         end
         ST_DW1: begin
            div_num = NUM_W'(frc_ff);
            div_den = DEN_W'(k2_ff);
            skip = (frc_ff == 9'd0);
         end
         ST_DW2: begin
            div_num = NUM_W'(src_ff);
            div_den = DEN_W'(k1_ff);
            skip = (src_ff == 9'd0);
         end
         default: begin div_num = '0; div_den = '0; end
      endcase
      div_start = !go_ff && !skip &&
                  (state_ff == ST_DP || state_ff == ST_DQ || state_ff == ST_DHJ ||
                   state_ff == ST_DHI || state_ff == ST_DS || state_ff == ST_DMAG ||
                   state_ff == ST_DR2 || state_ff == ST_DMEAN || state_ff == ST_DW1 ||
                   state_ff == ST_DW2);
   end

   ldr2_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .quot  (quot),
      .done  (div_done)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         sample_count_ff <= 16'd2;
         rare_thr_ff     <= 16'd0;
         go_ff           <= 1'b0;
         for (int i = 0; i < 9; i++) t_ff[i] <= '0;
         r2sum_ff <= '0;
         pc_ff    <= '0;
         dc_ff    <= '0;
         frc_ff   <= '0;
         src_ff   <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_SAMPLE_COUNT: sample_count_ff <= csr_wdata;
               CSR_RARE_THRESHOLD: rare_thr_ff <= csr_wdata;
            endcase
         end
         if (div_start) go_ff <= 1'b1;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  for (int i = 0; i < 9; i++) begin
                     if (cell_idx == 4'(i) && t_ff[i] != {CW{1'b1}}) t_ff[i] <= t_ff[i] + 1'b1;
                  end
                  if (req_tlast) begin
                     lastp_ff <= req_tuser;
                     k1_ff    <= k1_in;
                     k2_ff    <= k2_in;
                     state_ff <= ST_THR;
                  end
               end
            end
            ST_THR: begin
               prod_ff  <= prod_in;
               state_ff <= ST_FILT;
            end
            ST_FILT: begin
               for (int i = 0; i < 9; i++) begin
                  ft_ff[i] <= f[i];
                  t_ff[i]  <= '0;
               end
               state_ff <= ST_DP;
            end
            ST_DP: if (go_ff && div_done) begin
               go_ff <= 1'b0;
               p_ff <= (quot > NUM_W'(FONE)) ? FONE : quot[FRAC_W:0];
               state_ff <= ST_DQ;
            end
            ST_DQ: if (go_ff && div_done) begin
               go_ff <= 1'b0;
               q_ff <= (quot > NUM_W'(FONE)) ? FONE : quot[FRAC_W:0];
               state_ff <= ST_DHJ;
            end
            ST_DHJ: if (go_ff && div_done) begin
               go_ff <= 1'b0;
               hj_ff <= (quot > NUM_W'(FONE)) ? FONE : quot[FRAC_W:0];
               state_ff <= ST_DHI;
            end
            ST_DHI: if (go_ff && div_done) begin
               go_ff <= 1'b0;
               hi_ff <= (quot > NUM_W'(FONE)) ? FONE : quot[FRAC_W:0];
               state_ff <= ST_DS;
            end
            ST_DS: if (go_ff && div_done) begin
               go_ff <= 1'b0;
               s_ff <= (quot > NUM_W'({FONE, 1'b0})) ? {FONE, 1'b0} : quot[FRAC_W+1:0];
               state_ff <= ST_MPQ;
            end
            ST_MPQ: begin
               prod_ff  <= prod_in;
               state_ff <= ST_DELTA;
            end
            ST_DELTA: begin
               dmag_ff  <= delta[26] ? (27'd0 - delta) : delta;
               state_ff <= ST_MDN;
            end
            ST_MDN: begin
               prod_ff  <= prod_in;
               state_ff <= ST_DMAG;
            end
            ST_DMAG: if (go_ff && div_done) begin
               go_ff <= 1'b0;
               mag_ff <= quot[27:0];
               state_ff <= ST_V1A;
            end
            ST_V1A: begin
               prod_ff  <= prod_in;
               state_ff <= ST_V1B;
            end
            ST_V1B: begin
               va_ff    <= prod_ff[51:0] + {3'b0, hj_ff, 24'b0};
               prod_ff  <= prod_in;
               state_ff <= ST_V1;
            end
            ST_V1: begin
               v1neg_ff <= v_in[51];
               v1mag_ff <= vabs[51:24];
               state_ff <= ST_V2A;
            end
            ST_V2A: begin
               prod_ff  <= prod_in;
               state_ff <= ST_V2B;
            end
            ST_V2B: begin
               va_ff    <= prod_ff[51:0] + {3'b0, hi_ff, 24'b0};
               prod_ff  <= prod_in;
               state_ff <= ST_V2;
            end
            ST_V2: begin
               v2neg_ff <= v_in[51];
               v2mag_ff <= vabs[51:24];
               state_ff <= ST_MNUM;
            end
            ST_MNUM: begin
               prod_ff  <= prod_in;
               state_ff <= ST_MDEN;
            end
            ST_MDEN: begin
               num_ff   <= prod_ff[55:0];
               prod_ff  <= prod_in;
               state_ff <= ST_DR2;
            end
            ST_DR2: begin
               if (skip) begin
                  r2_ff    <= '0;
                  zden_ff  <= 1'b1;
                  state_ff <= ST_FIN;
               end else if (go_ff && div_done) begin
                  go_ff    <= 1'b0;
                  zden_ff  <= 1'b0;
                  r2_ff    <= (quot > NUM_W'(WORD_MAX)) ? WORD_MAX : quot[31:0];
                  state_ff <= ST_FIN;
               end
            end
            ST_FIN: begin
               rare1_ff <= rare1_in;
               rare2_ff <= rare2_in;
               drop_ff  <= rare1_in || rare2_in;
               r2_ff    <= r2_final[31:0];
               r2sum_ff <= sum_in[40] ? SUM_MAX : sum_in[39:0];
               if (pc_ff < SMALL_MAX) pc_ff <= pc_ff + 1'b1;
               if ((rare1_in || rare2_in) && dc_ff < SMALL_MAX) dc_ff <= dc_ff + 1'b1;
               if (rare1_in && frc_ff < SMALL_MAX) frc_ff <= frc_ff + 1'b1;
               if (rare2_in && src_ff < SMALL_MAX) src_ff <= src_ff + 1'b1;
               lvalid_ff  <= lastp_ff;
               mean_ff    <= '0;
               weight_ff  <= '0;
               alldrop_ff <= 1'b0;
               state_ff   <= lastp_ff ? ST_DMEAN : ST_OUT;
            end
            ST_DMEAN: begin
               if (skip) begin
                  mean_ff    <= '0;
                  alldrop_ff <= 1'b1;
                  state_ff   <= ST_DW1;
               end else if (go_ff && div_done) begin
                  go_ff    <= 1'b0;
                  mean_ff  <= (quot > NUM_W'(WORD_MAX)) ? WORD_MAX : quot[31:0];
                  state_ff <= ST_DW1;
               end
            end
            ST_DW1: begin
               if (skip) begin
                  part1_ff <= k1_ff - 1'b1;
                  state_ff <= ST_DW2;
               end else if (go_ff && div_done) begin
                  go_ff    <= 1'b0;
                  part1_ff <= (quot >= NUM_W'(k1_ff)) ? '0 : (k1_ff - quot[KW-1:0]);
                  state_ff <= ST_DW2;
               end
            end
            ST_DW2: begin
               if (skip) begin
                  part2_ff <= k2_ff - 1'b1;
                  state_ff <= ST_MW;
               end else if (go_ff && div_done) begin
                  go_ff    <= 1'b0;
                  part2_ff <= (quot >= NUM_W'(k2_ff)) ? '0 : (k2_ff - quot[KW-1:0]);
                  state_ff <= ST_MW;
               end
            end
            ST_MW: begin
               prod_ff  <= prod_in;
               state_ff <= ST_WGT;
            end
            ST_WGT: begin
               weight_ff <= (prod_ff > 64'(SMALL_MAX)) ? SMALL_MAX : prod_ff[8:0];
               state_ff  <= ST_OUT;
            end
            ST_OUT: begin
               if (rsp_tready) begin
                  if (lastp_ff) begin
                     r2sum_ff <= '0;
                     pc_ff    <= '0;
                     dc_ff    <= '0;
                     frc_ff   <= '0;
                     src_ff   <= '0;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = {1'b0, alldrop_ff, weight_ff, mean_ff, lvalid_ff, zden_ff,
                        rare2_ff, rare1_ff, drop_ff, r2_ff};

endmodule
